/* src/tcw_pkg.sv */
package tcw_pkg;

  // Item function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  // Attribute of every cell after reset, also the attribute registers' reset value
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam logic [4:0] TAB_SIZE_RST = 5'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_TEXT_ATTR  = 3'd0;
  localparam logic [2:0] REG_BLANK_ATTR = 3'd1;
  localparam logic [2:0] REG_TAB_SIZE   = 3'd2;
  localparam logic [2:0] REG_RUBOUT_COL = 3'd3;
  localparam logic [2:0] REG_RUBOUT_ROW = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAB,
    ST_BS_RD,
    ST_BS_CHK,
    ST_SCROLL,
    ST_READ,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } tcw_out_t;

  typedef struct packed {
    logic [7:0]        text_attribute;
    logic [7:0]        blank_attribute;
    logic [4:0]        tab_size;
    logic signed [7:0] rubout_limit_col;
    logic [4:0]        rubout_limit_row;
  } tcw_cfg_t;

endpackage

/* src/tcw_rem_unit.sv */
module tcw_rem_unit #(
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [4:0]    divisor_i,
  output logic          done_o,
  output logic [4:0]    rem_o
);

  localparam int SW = (DW > 1) ? $clog2(DW) : 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(DW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [4:0]    rem_q, rem_d;
  logic [DW-1:0] num_q, num_d;
  logic [4:0]    div_q, div_d;

  logic [5:0] part;
  logic [5:0] diff;
  logic [4:0] rem_step;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    part     = {rem_q, num_q[DW-1]};
    diff     = part - {1'b0, div_q};
    rem_step = (part >= {1'b0, div_q}) ? diff[4:0] : part[4:0];
  end

  // Sequence the steps, one dividend bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem_step;
      num_d = num_q << 1;
      cnt_d = cnt_q + SW'(1);
      if (cnt_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* src/tcw_ctrl.sv */
module tcw_ctrl #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_pkg::tcw_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output tcw_pkg::tcw_out_t res_o
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int NW = $clog2(CELL_COUNT + 1);
  localparam int CW = $clog2(SCREEN_COLS);
  localparam int RW = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;
  localparam int MOVE_COUNT = CELL_COUNT - SCREEN_COLS;

  localparam logic [CW-1:0] COL_LAST = CW'(SCREEN_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);
  localparam logic [NW-1:0] MOVE_END = NW'(MOVE_COUNT);
  localparam logic [NW-1:0] CNT_END  = NW'(CELL_COUNT);
  localparam logic [NW-1:0] CLR_END  = NW'(CELL_COUNT - 1);
  localparam logic [NW-1:0] ROW_SPAN = NW'(SCREEN_COLS);
  localparam logic [AW-1:0] COLS_A   = AW'(SCREEN_COLS);

  tcw_state_e state_q, state_d;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [4:0]    ts_q, ts_d;
  logic          hit_q, hit_d;
  logic [7:0]    res_char_q, res_char_d;
  logic [7:0]    res_attr_q, res_attr_d;

  // Screen store
  logic [15:0]   mem_q [CELL_COUNT];
  logic [15:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Shared cell address unit
  logic [RW-1:0] addr_row;
  logic [CW-1:0] addr_col;
  logic [AW-1:0] addr_lin;

  logic        accept;
  logic        is_read;
  logic        read_hit;
  logic        bs_ok;
  logic        col_last;
  logic        row_last;
  logic [7:0]  ch;
  logic [15:0] blank_cell;
  logic [4:0]  ts_eff;
  logic        rem_start;
  logic        rem_done;
  logic [4:0]  rem;
  logic [7:0]  tab_sum;

  tcw_rem_unit #(
    .DW (CW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (col_q),
    .divisor_i  (ts_eff),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Decode the offered item and the cursor position
  always_comb begin
    accept     = in_valid_i && (state_q == ST_IDLE);
    is_read    = (in_data_i.func == FUNC_READ);
    ch         = in_data_i.char_code;
    read_hit   = (32'(in_data_i.cell_index) < 32'(CELL_COUNT));
    col_last   = (col_q == COL_LAST);
    row_last   = (row_q == ROW_LAST);
    bs_ok      = (7'(row_q) >= 7'(cfg_i.rubout_limit_row)) &&
                 ($signed(9'(col_q)) > 9'(cfg_i.rubout_limit_col));
    blank_cell = {cfg_i.blank_attribute, NUL_CHAR};
    ts_eff     = (cfg_i.tab_size == 5'd0) ? 5'd1 : cfg_i.tab_size;
    tab_sum    = 8'(col_q) + 8'(ts_q) - 8'(rem);
    addr_lin   = AW'(addr_row) * COLS_A + AW'(addr_col);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CLR_END) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (is_read) begin
            state_d = ST_READ;
          end else begin
            case (ch)
              CH_LF:  state_d = row_last ? ST_SCROLL : ST_DONE;
              CH_CR:  state_d = ST_DONE;
              CH_TAB: state_d = ST_TAB;
              CH_BS: begin
                if (bs_ok && col_q == '0 && row_q != '0) state_d = ST_BS_RD;
                else state_d = ST_DONE;
              end
              default: state_d = (col_last && row_last) ? ST_SCROLL : ST_DONE;
            endcase
          end
        end
      end
      ST_TAB: begin
        if (rem_done) begin
          state_d = (tab_sum >= 8'(SCREEN_COLS) && row_last) ? ST_SCROLL : ST_DONE;
        end
      end
      ST_BS_RD:  state_d = ST_BS_CHK;
      ST_BS_CHK: begin
        if (rdata_q[7:0] != NUL_CHAR || col_q == '0) state_d = ST_DONE;
        else state_d = ST_BS_RD;
      end
      ST_SCROLL: begin
        if (cnt_q == CNT_END) state_d = ST_DONE;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath, store access and handshake outputs
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    cnt_d      = '0;
    ts_d       = ts_q;
    hit_d      = hit_q;
    res_char_d = res_char_q;
    res_attr_d = res_attr_q;
    mem_we     = 1'b0;
    mem_waddr  = addr_lin;
    mem_wdata  = blank_cell;
    mem_raddr  = '0;
    addr_row   = row_q;
    addr_col   = col_q;
    rem_start  = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d     = cnt_q + NW'(1);
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_q);
        mem_wdata = {RESET_ATTR, NUL_CHAR};
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          res_char_d = NUL_CHAR;
          res_attr_d = 8'h00;
          if (is_read) begin
            hit_d = read_hit;
            if (read_hit) mem_raddr = AW'(in_data_i.cell_index);
          end else begin
            case (ch)
              CH_LF: begin
                col_d = '0;
                if (!row_last) row_d = row_q + RW'(1);
              end
              CH_CR: col_d = '0;
              CH_TAB: begin
                rem_start = 1'b1;
                ts_d      = ts_eff;
              end
              CH_BS: begin
                if (bs_ok) begin
                  if (col_q != '0) begin
                    // Erase the cell to the left and step onto it
                    col_d    = col_q - CW'(1);
                    addr_col = col_q - CW'(1);
                    mem_we   = 1'b1;
                  end else if (row_q != '0) begin
                    // Join the previous row: blank its last cell, then scan left
                    row_d    = row_q - RW'(1);
                    col_d    = COL_LAST - CW'(1);
                    addr_row = row_q - RW'(1);
                    addr_col = COL_LAST;
                    mem_we   = 1'b1;
                  end
                end
              end
              default: begin
                mem_we    = 1'b1;
                mem_wdata = {cfg_i.text_attribute, ch};
                if (col_last) begin
                  col_d = '0;
                  if (!row_last) row_d = row_q + RW'(1);
                end else begin
                  col_d = col_q + CW'(1);
                end
              end
            endcase
          end
        end
      end
      ST_TAB: begin
        if (rem_done) begin
          if (tab_sum >= 8'(SCREEN_COLS)) begin
            col_d = '0;
            if (!row_last) row_d = row_q + RW'(1);
          end else begin
            col_d = CW'(tab_sum);
          end
        end
      end
      ST_BS_RD: begin
        mem_raddr = addr_lin;
      end
      ST_BS_CHK: begin
        if (rdata_q[7:0] != NUL_CHAR) col_d = col_q + CW'(1);
        else if (col_q != '0) col_d = col_q - CW'(1);
      end
      ST_SCROLL: begin
        // Stream each cell up one row; the last row is blanked
        cnt_d = cnt_q + NW'(1);
        if (cnt_q < MOVE_END) mem_raddr = AW'(cnt_q + ROW_SPAN);
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_q - NW'(1));
          mem_wdata = (cnt_q <= MOVE_END) ? rdata_q : blank_cell;
        end
      end
      ST_READ: begin
        res_char_d = hit_q ? rdata_q[7:0]  : 8'h00;
        res_attr_d = hit_q ? rdata_q[15:8] : 8'h00;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q       <= ts_d;
    hit_q      <= hit_d;
    res_char_q <= res_char_d;
    res_attr_q <= res_attr_d;
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

  assign res_o.cursor_col    = 7'(col_q);
  assign res_o.cursor_row    = 5'(row_q);
  assign res_o.cursor_offset = 11'(addr_lin);
  assign res_o.cell_char     = res_char_q;
  assign res_o.cell_attr     = res_attr_q;

  cursor_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (col_q <= COL_LAST && row_q <= ROW_LAST))
    else $error("cursor outside the screen while idle");

  read_goes_to_read_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.func == FUNC_READ) |=> (state_q == ST_READ))
    else $error("read transfer did not start a store read");

  scroll_ends_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && cnt_q == CNT_END) |=> (state_q == ST_DONE))
    else $error("scroll pass did not finish after the last cell");

  tab_finishes_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAB && rem_done) |=> (state_q == ST_DONE || state_q == ST_SCROLL))
    else $error("tab did not complete when the remainder was ready");

endmodule

/* src/text_console_char_writer_top.sv */
// Channel  Direction  Handshake                 Payload
// cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i  / in_ready_o   in_data_i  (tcw_in_t)
// out      out        out_valid_o / out_ready_i  out_data_o (tcw_out_t)
//
// States: a read passes IDLE, READ, DONE; newline, return, plain character and simple
// backspace pass IDLE, DONE; a tab also waits in TAB, one remainder bit per cycle.
// A row-joining backspace alternates BS_RD and BS_CHK for each cell scanned.
// A scroll adds a pass through SCROLL, one store cell moved per cycle.
// Reset sweeps every store cell to char 0, attribute 7 in the CLEAR state;
// no item is taken meanwhile, configuration writes are. A waiting result blocks the next.
module text_console_char_writer_top #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_out_t out_data_o
);

  import tcw_pkg::*;

  tcw_cfg_t cfg_q, cfg_d;
  logic     out_valid_q, out_valid_d;
  tcw_out_t out_q;
  logic     out_free;
  logic     res_valid;
  tcw_out_t res;

  tcw_ctrl #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Decode configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEXT_ATTR:  cfg_d.text_attribute   = cfg_data_i;
        REG_BLANK_ATTR: cfg_d.blank_attribute  = cfg_data_i;
        REG_TAB_SIZE:   cfg_d.tab_size         = cfg_data_i[4:0];
        REG_RUBOUT_COL: cfg_d.rubout_limit_col = $signed(cfg_data_i);
        REG_RUBOUT_ROW: cfg_d.rubout_limit_row = cfg_data_i[4:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_attribute   <= RESET_ATTR;
      cfg_q.blank_attribute  <= RESET_ATTR;
      cfg_q.tab_size         <= TAB_SIZE_RST;
      cfg_q.rubout_limit_col <= '0;
      cfg_q.rubout_limit_row <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Hold the result until the output transfer
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && out_free) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* test/tb_text_console_char_writer_top.sv */
`timescale 1ns / 100ps

module tb_text_console_char_writer_top;
  import tcw_pkg::*;

  localparam int COLS            = 80;
  localparam int ROWS            = 25;
  localparam int CELLS           = COLS * ROWS;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 125;
  // a scroll plus a full row-joining backspace, with margin
  localparam int LINGER_CYCLES   = CELLS + 2 * COLS + 40;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic     in_valid_i;
  logic     in_ready_o;
  tcw_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  tcw_out_t out_data_o;

  text_console_char_writer_top #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the console: screen image, cursor and registers
  logic [15:0] screen_image [CELLS];
  int          cur_x;
  int          cur_y;
  tcw_cfg_t    cfg_now;

  tcw_out_t pending_results [$];
  bit       quiet;
  int       mismatch_count;
  int       items_sent;
  int       reads_sent;
  int       results_checked;
  int       reg_writes;
  int       scroll_count;
  int       row_joins;

  function automatic logic [15:0] blank_word();
    return {cfg_now.blank_attribute, NUL_CHAR};
  endfunction

  // Shift the image up one row and blank the bottom row
  function automatic void scroll_image();
    for (int i = 0; i < CELLS - COLS; i++) screen_image[i] = screen_image[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen_image[i] = blank_word();
    scroll_count++;
  endfunction

  // Erase left of the cursor, joining the previous row at column 0
  function automatic void rub_out();
    if (cur_x > 0) begin
      cur_x--;
      screen_image[cur_y * COLS + cur_x] = blank_word();
      return;
    end
    if (cur_y == 0) return;
    row_joins++;
    cur_y--;
    cur_x = COLS - 1;
    screen_image[cur_y * COLS + cur_x] = blank_word();
    while (screen_image[cur_y * COLS + cur_x][7:0] == NUL_CHAR) begin
      cur_x--;
      if (cur_x == 0) begin
        if (screen_image[cur_y * COLS][7:0] == NUL_CHAR) return;
        break;
      end
    end
    cur_x++;
  endfunction

  // Apply one item to the shadow and return the result it should give
  function automatic tcw_out_t console_step(input tcw_in_t it);
    tcw_out_t res;
    int       ts;
    res = '0;
    if (it.func == FUNC_READ) begin
      if (int'(it.cell_index) < CELLS) begin
        res.cell_char = screen_image[it.cell_index][7:0];
        res.cell_attr = screen_image[it.cell_index][15:8];
      end
    end else begin
      case (it.char_code)
        CH_LF: begin
          cur_x = 0;
          cur_y++;
        end
        CH_BS: begin
          if (cur_y >= int'(cfg_now.rubout_limit_row) &&
              cur_x > int'($signed(cfg_now.rubout_limit_col))) rub_out();
        end
        CH_TAB: begin
          ts = (cfg_now.tab_size == 5'd0) ? 1 : int'(cfg_now.tab_size);
          cur_x = cur_x + ts - (cur_x % ts);
          if (cur_x >= COLS) begin
            cur_x = 0;
            cur_y++;
          end
        end
        CH_CR: cur_x = 0;
        default: begin
          screen_image[cur_y * COLS + cur_x] = {cfg_now.text_attribute, it.char_code};
          cur_x++;
          if (cur_x >= COLS) begin
            cur_x = 0;
            cur_y++;
          end
        end
      endcase
      if (cur_y >= ROWS) begin
        cur_y = ROWS - 1;
        scroll_image();
      end
    end
    res.cursor_col    = 7'(cur_x);
    res.cursor_row    = 5'(cur_y);
    res.cursor_offset = 11'(cur_y * COLS + cur_x);
    return res;
  endfunction

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lower the input valid and wait until every expected result is in
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TEXT_ATTR:  cfg_now.text_attribute   = val;
      REG_BLANK_ATTR: cfg_now.blank_attribute  = val;
      REG_TAB_SIZE:   cfg_now.tab_size         = val[4:0];
      REG_RUBOUT_COL: cfg_now.rubout_limit_col = $signed(val);
      REG_RUBOUT_ROW: cfg_now.rubout_limit_row = val[4:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_console(input logic [7:0] text, input logic [7:0] blank,
                             input int tab, input int col, input int row);
    write_reg(REG_TEXT_ATTR, text);
    write_reg(REG_BLANK_ATTR, blank);
    write_reg(REG_TAB_SIZE, 8'(tab));
    write_reg(REG_RUBOUT_COL, 8'(col));
    write_reg(REG_RUBOUT_ROW, 8'(row));
  endtask

  // Offer one item, hold it until the transfer, then log its expected result
  task automatic put_item(input tcw_in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(console_step(it));
    items_sent++;
    if (it.func == FUNC_READ) reads_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    tcw_in_t it;
    it.func       = FUNC_PUT;
    it.char_code  = ch;
    it.cell_index = 11'($urandom);
    put_item(it);
  endtask

  task automatic send_read(input int idx);
    tcw_in_t it;
    it.func       = FUNC_READ;
    it.char_code  = 8'($urandom);
    it.cell_index = 11'(idx);
    put_item(it);
  endtask

  function automatic tcw_in_t random_item();
    tcw_in_t it;
    int      k;
    int      base;
    it.func       = FUNC_PUT;
    it.char_code  = 8'($urandom);
    it.cell_index = 11'($urandom);
    k = $urandom_range(0, 99);
    if (k < 12) begin
      it.func = FUNC_READ;
      k = $urandom_range(0, 9);
      if (k < 5) begin
        base = cur_y * COLS + cur_x - int'($urandom_range(0, 100));
        it.cell_index = 11'((base < 0) ? 0 : base);
      end else if (k < 9) begin
        it.cell_index = 11'($urandom_range(0, CELLS - 1));
      end else begin
        it.cell_index = 11'($urandom_range(CELLS, 2047));
      end
    end else if (k < 20) begin
      it.char_code = CH_LF;
    end else if (k < 24) begin
      it.char_code = CH_CR;
    end else if (k < 32) begin
      it.char_code = CH_TAB;
    end else if (k < 46) begin
      it.char_code = CH_BS;
    end else if ($urandom_range(0, 9) == 0) begin
      it.char_code = NUL_CHAR;
    end
    return it;
  endfunction

  // Cleared store: first and last cells, plus an index past the end
  task automatic test_reset_image();
    send_read(0);
    send_read(CELLS - 1);
    send_read(2047);
  endtask

  task automatic test_put_and_controls();
    write_reg(REG_TEXT_ATTR, 8'hA5);
    send_char(8'h41);
    send_char(8'hFF);
    send_char(NUL_CHAR);
    send_read(2);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_BS);
    send_char(CH_LF);
  endtask

  // Tab size zero, size sixteen with a wrap past the row end, and size one
  task automatic test_tab_stops();
    write_reg(REG_TAB_SIZE, 8'd0);
    send_char(CH_TAB);
    write_reg(REG_TAB_SIZE, 8'd16);
    repeat (5) send_char(CH_TAB);
    write_reg(REG_TAB_SIZE, 8'd1);
    send_char(CH_TAB);
  endtask

  // Erase in a row, join an empty row, join a row ending in NUL, then refusals
  task automatic test_rubout();
    write_reg(REG_BLANK_ATTR, 8'h3C);
    write_reg(REG_RUBOUT_COL, 8'hFF);
    send_char(CH_BS);
    send_char(CH_BS);
    send_char(CH_BS);
    send_char(CH_CR);
    send_char(CH_BS);
    send_char(8'h79);
    write_reg(REG_RUBOUT_ROW, 8'd24);
    send_char(CH_BS);
    write_reg(REG_RUBOUT_ROW, 8'd0);
    write_reg(REG_RUBOUT_COL, 8'd79);
    send_char(CH_BS);
  endtask

  task automatic test_random_text();
    int k;
    int col;
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiet = (p == 3 || p == 6);
      case (p)
        0: set_console(8'h00, 8'h00, 1, -1, 0);
        1: set_console(8'hFF, 8'hFF, 16, 79, 24);
        default: begin
          k = $urandom_range(0, 9);
          col = (k < 5) ? -1 : (k < 8) ? int'($urandom_range(0, 10))
                                      : int'($urandom_range(11, 79));
          set_console(8'($urandom), 8'($urandom), int'($urandom_range(1, 16)), col,
                      ($urandom_range(0, 9) < 7) ? 0 : int'($urandom_range(0, 24)));
        end
      endcase
      repeat (ITEMS_PER_PHASE) put_item(random_item());
    end
    quiet = 1'b0;
  endtask

  // Push past the last row, read the freshly blanked bottom row and the start of the row above
  task automatic test_scroll();
    write_reg(REG_BLANK_ATTR, 8'h5A);
    while (cur_y < ROWS - 1) send_char(CH_LF);
    send_char(CH_LF);
    send_read(CELLS - 1);
    send_read((ROWS - 2) * COLS);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Mismatch in %s at %0t: expected %0d, got %0d", name, $time, exp_v, act_v);
    end
  endtask

  // Compare each result transfer with the oldest expectation
  initial begin
    tcw_out_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result at %0t: %h", $time, out_data_o);
        end else begin
          exp_r = pending_results.pop_front();
          results_checked++;
          check_field("cursor_col", exp_r.cursor_col, out_data_o.cursor_col);
          check_field("cursor_row", exp_r.cursor_row, out_data_o.cursor_row);
          check_field("cursor_offset", exp_r.cursor_offset, out_data_o.cursor_offset);
          check_field("cell_char", exp_r.cell_char, out_data_o.cell_char);
          check_field("cell_attr", exp_r.cell_attr, out_data_o.cell_attr);
        end
      end
    end
  end

  // Result side: random stalls of mixed length
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Watchdog expired with %0d results outstanding", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    quiet       = 1'b0;
    for (int i = 0; i < CELLS; i++) screen_image[i] = {RESET_ATTR, NUL_CHAR};
    cur_x   = 0;
    cur_y   = 0;
    cfg_now = '{text_attribute: RESET_ATTR, blank_attribute: RESET_ATTR,
                tab_size: TAB_SIZE_RST, rubout_limit_col: 8'sd0, rubout_limit_row: 5'd0};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_image();
    test_put_and_controls();
    test_tab_stops();
    test_rubout();
    test_random_text();
    test_scroll();

    // Drain, then linger to catch any stray result
    wait_drained();
    repeat (LINGER_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d reads), checked %0d results, %0d register writes",
             items_sent, reads_sent, results_checked, reg_writes);
    $display("Shadow saw %0d scrolls and %0d row-joining backspaces; %0d mismatches",
             scroll_count, row_joins, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
